/* rtl/qrv_pkg.sv */
package qrv_pkg;

   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 32;
   localparam int CORDIC_W   = 60;
   localparam int ANGLE_W    = 34;
   localparam int PRE_SHIFT  = 24;
   localparam int MARGIN_W   = 10;
   localparam int NUM_W      = 65;
   localparam int DEN_W      = 33;

   localparam logic signed [ANGLE_W-1:0] HALF_PI = 34'sd1686629713;
   localparam logic signed [32:0]        ONE_Q30 = 33'sd1073741824;
   localparam logic [MARGIN_W-1:0]       MARGIN_RESET = 10'd1;

   localparam logic [ANGLE_W-1:0] ATAN_HEAD [11] = '{
      34'd843314856, 34'd497837829, 34'd263043836, 34'd133525158, 34'd67021686,
      34'd33543515, 34'd16775850, 34'd8388437, 34'd4194282, 34'd2097149, 34'd1048575
   };

   typedef struct packed {
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] rot_x;
      logic signed [31:0] rot_y;
      logic signed [31:0] rot_z;
      logic               degenerate;
   } rsp_type;

   // classified word as it waits between front and back
   typedef struct packed {
      logic               series;
      logic [2:0]         neg;
      logic [2:0][31:0]   mag;
      logic signed [31:0] w;
   } info_type;

   typedef struct packed {
      logic       series;
      logic       degen;
      logic [2:0] neg;
   } ctl_type;

   // angle step of CORDIC stage i in units of 2^-30 rad
   function automatic logic [ANGLE_W-1:0] atan_entry(input int unsigned i);
      logic [ANGLE_W-1:0] val;
      if (i < 11) begin
         val = ATAN_HEAD[i[3:0]];
      end else if (i <= 30) begin
         val = (34'd1 << (30 - i)) - 34'd1;
      end else begin
         val = '0;
      end
      return val;
   endfunction

endpackage

/* rtl/qrv_front.sv */
module qrv_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  qrv_pkg::req_type   req_data,
   output logic               req_stall,
   input  logic               csr_wr_en,
   input  logic [9:0]         csr_wr_data,
   input  logic               q_full,
   output logic               q_push,
   output qrv_pkg::info_type  q_info
);
   import qrv_pkg::*;

   logic [MARGIN_W-1:0] margin_ff;
   logic [MARGIN_W-1:0] margin_in;
   logic signed [32:0]  diff;
   logic signed [32:0]  margin_ext;
   logic [2:0][31:0]    comp;

   assign margin_in = csr_wr_en ? csr_wr_data : margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
      end else begin
         margin_ff <= margin_in;
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   assign comp[0] = req_data.quat_x;
   assign comp[1] = req_data.quat_y;
   assign comp[2] = req_data.quat_z;

   // one minus w, in LSBs, against the margin
   assign diff       = ONE_Q30 - {req_data.quat_w[31], req_data.quat_w};
   assign margin_ext = {23'd0, margin_ff};

   always_comb begin
      q_info.series = diff < margin_ext;
      q_info.w      = req_data.quat_w;
      for (int k = 0; k < 3; k++) begin
         q_info.neg[k] = comp[k][31];
         q_info.mag[k] = comp[k][31] ? (~comp[k] + 32'd1) : comp[k];
      end
   end

endmodule

/* rtl/qrv_queue.sv */
module qrv_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  qrv_pkg::info_type  push_info,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output qrv_pkg::info_type  pop_info
);
   import qrv_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   info_type          mem_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign full      = count_ff == CntW'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_info  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_info;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("queue count above depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");

endmodule

/* rtl/qrv_divide.sv */
module qrv_divide (
   input  logic                      clock,
   input  logic                      advance,
   input  logic [qrv_pkg::NUM_W-1:0] num,
   input  logic [qrv_pkg::DEN_W-1:0] den,
   output logic [31:0]               quo
);
   import qrv_pkg::*;

   logic [DEN_W-1:0] rem_ff [DIV_STEPS];
   logic [31:0]      low_ff [DIV_STEPS];
   logic [31:0]      quo_ff [DIV_STEPS];
   logic [DEN_W-1:0] den_ff [DIV_STEPS];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      logic [DEN_W-1:0] rem_prev, den_prev, rem_in;
      logic [31:0]      low_prev, quo_prev, quo_in, low_in;
      logic [DEN_W:0]   trial;
      logic             ge;

      if (j == 0) begin : g_first
         // quotient fits 32 bits, so the top part is already below den
         assign rem_prev = num[NUM_W-1:32];
         assign low_prev = num[31:0];
         assign quo_prev = '0;
         assign den_prev = den;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign low_prev = low_ff[j-1];
         assign quo_prev = quo_ff[j-1];
         assign den_prev = den_ff[j-1];
      end

      always_comb begin
         trial  = {rem_prev, low_prev[31]};
         ge     = trial >= {1'b0, den_prev};
         rem_in = ge ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
         quo_in = {quo_prev[30:0], ge};
         low_in = {low_prev[30:0], 1'b0};
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j] <= rem_in;
            low_ff[j] <= low_in;
            quo_ff[j] <= quo_in;
            den_ff[j] <= den_prev;
         end
      end
   end

   assign quo = quo_ff[DIV_STEPS-1];

endmodule

/* rtl/qrv_back.sv */
module qrv_back #(
   parameter int CORDIC_STAGES = 30
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  qrv_pkg::info_type  q_info,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output qrv_pkg::rsp_type   rsp_data
);
   import qrv_pkg::*;

   logic adv;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   // whole pipe moves together; it freezes only while a result waits
   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign q_pop = adv && q_valid;

   // squares
   logic             a_vld_ff;
   info_type         a_info_ff;
   logic [2:0][63:0] a_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_info_ff <= q_info;
         for (int k = 0; k < 3; k++) begin
            a_sq_ff[k] <= 64'(q_info.mag[k]) * 64'(q_info.mag[k]);
         end
      end
   end

   // sum of squares
   logic        b_vld_ff;
   info_type    b_info_ff;
   logic [63:0] b_s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_info_ff <= a_info_ff;
         b_s_ff    <= a_sq_ff[0] + a_sq_ff[1] + a_sq_ff[2];
      end
   end

   // integer square root, one result bit per stage
   logic        c_vld_ff  [SQRT_STEPS];
   info_type    c_info_ff [SQRT_STEPS];
   logic [63:0] c_n_ff    [SQRT_STEPS];
   logic [63:0] c_r_ff    [SQRT_STEPS];

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      localparam logic [63:0] StepBit = 64'd1 << (62 - 2 * j);
      logic        vld_prev;
      info_type    info_prev;
      logic [63:0] n_prev, r_prev, trial, n_in, r_in;

      if (j == 0) begin : g_first
         assign vld_prev  = b_vld_ff;
         assign info_prev = b_info_ff;
         assign n_prev    = b_s_ff;
         assign r_prev    = '0;
      end else begin : g_next
         assign vld_prev  = c_vld_ff[j-1];
         assign info_prev = c_info_ff[j-1];
         assign n_prev    = c_n_ff[j-1];
         assign r_prev    = c_r_ff[j-1];
      end

      always_comb begin
         trial = r_prev + StepBit;
         if (n_prev >= trial) begin
            n_in = n_prev - trial;
            r_in = (r_prev >> 1) + StepBit;
         end else begin
            n_in = n_prev;
            r_in = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            c_vld_ff[j] <= 1'b0;
         end else if (adv) begin
            c_vld_ff[j] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            c_info_ff[j] <= info_prev;
            c_n_ff[j]    <= n_in;
            c_r_ff[j]    <= r_in;
         end
      end
   end

   logic [31:0] c_mag;
   assign c_mag = c_r_ff[SQRT_STEPS-1][31:0];

   // vectoring CORDIC on (w, |v|)
   logic                        d_vld_ff  [CORDIC_STAGES];
   info_type                    d_info_ff [CORDIC_STAGES];
   logic [31:0]                 d_m_ff    [CORDIC_STAGES];
   logic signed [CORDIC_W-1:0]  d_x_ff    [CORDIC_STAGES];
   logic signed [CORDIC_W-1:0]  d_y_ff    [CORDIC_STAGES];
   logic signed [ANGLE_W-1:0]   d_z_ff    [CORDIC_STAGES];

   logic signed [CORDIC_W-1:0] m_ext, w_ext, x_init, y_init;
   logic signed [ANGLE_W-1:0]  z_init;

   always_comb begin
      m_ext = $signed({28'd0, c_mag});
      w_ext = {{28{c_info_ff[SQRT_STEPS-1].w[31]}}, c_info_ff[SQRT_STEPS-1].w};
      // left half plane: turn by a quarter first
      if (w_ext < 0) begin
         x_init = m_ext <<< PRE_SHIFT;
         y_init = (-w_ext) <<< PRE_SHIFT;
         z_init = HALF_PI;
      end else begin
         x_init = w_ext <<< PRE_SHIFT;
         y_init = m_ext <<< PRE_SHIFT;
         z_init = '0;
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      localparam logic signed [ANGLE_W-1:0] StepAngle = $signed(atan_entry(i));
      logic                       vld_prev;
      info_type                   info_prev;
      logic [31:0]                m_prev;
      logic signed [CORDIC_W-1:0] x_prev, y_prev, x_in, y_in;
      logic signed [ANGLE_W-1:0]  z_prev, z_in;

      if (i == 0) begin : g_first
         assign vld_prev  = c_vld_ff[SQRT_STEPS-1];
         assign info_prev = c_info_ff[SQRT_STEPS-1];
         assign m_prev    = c_mag;
         assign x_prev    = x_init;
         assign y_prev    = y_init;
         assign z_prev    = z_init;
      end else begin : g_next
         assign vld_prev  = d_vld_ff[i-1];
         assign info_prev = d_info_ff[i-1];
         assign m_prev    = d_m_ff[i-1];
         assign x_prev    = d_x_ff[i-1];
         assign y_prev    = d_y_ff[i-1];
         assign z_prev    = d_z_ff[i-1];
      end

      always_comb begin
         if (y_prev >= 0) begin
            x_in = x_prev + (y_prev >>> i);
            y_in = y_prev - (x_prev >>> i);
            z_in = z_prev + StepAngle;
         end else begin
            x_in = x_prev - (y_prev >>> i);
            y_in = y_prev + (x_prev >>> i);
            z_in = z_prev - StepAngle;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d_vld_ff[i] <= 1'b0;
         end else if (adv) begin
            d_vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            d_info_ff[i] <= info_prev;
            d_m_ff[i]    <= m_prev;
            d_x_ff[i]    <= x_in;
            d_y_ff[i]    <= y_in;
            d_z_ff[i]    <= z_in;
         end
      end
   end

   // numerators and divisor
   info_type    d_info;
   logic [31:0] d_m, ang;
   logic signed [ANGLE_W-1:0] d_z;

   assign d_info = d_info_ff[CORDIC_STAGES-1];
   assign d_m    = d_m_ff[CORDIC_STAGES-1];
   assign d_z    = d_z_ff[CORDIC_STAGES-1];
   // clamp residue below zero
   assign ang    = (d_z < 0) ? '0 : d_z[31:0];

   logic             e_vld_ff;
   ctl_type          e_ctl_ff;
   logic [2:0][63:0] e_prod_ff;
   logic [DEN_W-1:0] e_half_ff, e_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= d_vld_ff[CORDIC_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_ctl_ff.series <= d_info.series;
         e_ctl_ff.neg    <= d_info.neg;
         e_ctl_ff.degen  <= !d_info.series && (d_m == '0);
         for (int k = 0; k < 3; k++) begin
            if (d_info.series) begin
               // times 6 * 2^28
               e_prod_ff[k] <= (64'(d_info.mag[k]) << 30) + (64'(d_info.mag[k]) << 29);
            end else begin
               e_prod_ff[k] <= 64'(d_info.mag[k]) * 64'(ang);
            end
         end
         // w + 2^31 is w with its sign bit flipped
         if (d_info.series) begin
            e_den_ff  <= {1'b0, ~d_info.w[31], d_info.w[30:0]};
            e_half_ff <= {2'b0, ~d_info.w[31], d_info.w[30:1]};
         end else begin
            e_den_ff  <= {d_m, 1'b0};
            e_half_ff <= {1'b0, d_m};
         end
      end
   end

   logic                  f_vld_ff;
   ctl_type               f_ctl_ff;
   logic [2:0][NUM_W-1:0] f_num_ff;
   logic [DEN_W-1:0]      f_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ctl_ff <= e_ctl_ff;
         f_den_ff <= e_den_ff;
         for (int k = 0; k < 3; k++) begin
            f_num_ff[k] <= {1'b0, e_prod_ff[k]} + NUM_W'(e_half_ff);
         end
      end
   end

   // rounded quotients
   logic [2:0][31:0] quo;

   for (genvar k = 0; k < 3; k++) begin : g_div
      qrv_divide u_divide (
         .clock   (clock),
         .advance (adv),
         .num     (f_num_ff[k]),
         .den     (f_den_ff),
         .quo     (quo[k])
      );
   end

   logic    g_vld_ff [DIV_STEPS];
   ctl_type g_ctl_ff [DIV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DIV_STEPS; j++) begin
            g_vld_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         g_vld_ff[0] <= f_vld_ff;
         for (int j = 1; j < DIV_STEPS; j++) begin
            g_vld_ff[j] <= g_vld_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_ctl_ff[0] <= f_ctl_ff;
         for (int j = 1; j < DIV_STEPS; j++) begin
            g_ctl_ff[j] <= g_ctl_ff[j-1];
         end
      end
   end

   // sign, saturation and the degenerate case
   ctl_type          g_ctl;
   logic [2:0][31:0] rot;

   assign g_ctl = g_ctl_ff[DIV_STEPS-1];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (g_ctl.degen) begin
            rot[k] = '0;
         end else if (g_ctl.neg[k]) begin
            rot[k] = (quo[k] > 32'h8000_0000) ? 32'h8000_0000 : (~quo[k] + 32'd1);
         end else begin
            rot[k] = (quo[k] > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[k];
         end
      end
      rsp_data_in.rot_x      = rot[0];
      rsp_data_in.rot_y      = rot[1];
      rsp_data_in.rot_z      = rot[2];
      rsp_data_in.degenerate = g_ctl.degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= g_vld_ff[DIV_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.degenerate) |->
         (rsp_data_ff.rot_x == '0 && rsp_data_ff.rot_y == '0 && rsp_data_ff.rot_z == '0))
      else $error("degenerate word with nonzero rotation");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid_ff)
      else $error("result valid right after reset");

endmodule

/* rtl/quaternion_to_rotation_vector_unit.sv */
// Quaternion to rotation vector: takes one Q2.30 quaternion word per cycle and returns the
// Q4.28 rotation vector, one word per cycle sustained while no result is stalled. A word goes
// through the input queue, then squares, sum, a 32-stage square root, CORDIC_STAGES CORDIC
// stages, a multiply, a rounding add, a 32-stage divider and the output register; the long
// serial chains of the square root, CORDIC and divider make up most of that path. A stalled
// result freezes the back pipeline and the queue of QUEUE_DEPTH words absorbs the words that
// are still arriving. The small-angle margin is written through csr_wr_en/csr_wr_data; the
// user must write it only while the unit is idle, which the unit itself does not enforce.
module quaternion_to_rotation_vector_unit #(
   parameter int CORDIC_STAGES = 30,
   parameter int QUEUE_DEPTH   = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qrv_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qrv_pkg::rsp_type  rsp_data,
   input  logic              csr_wr_en,
   input  logic [9:0]        csr_wr_data
);
   import qrv_pkg::*;

   logic     q_full, q_push, q_pop, q_valid;
   info_type push_info, pop_info;

   qrv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_info      (push_info)
   );

   qrv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_info (push_info),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_info  (pop_info)
   );

   qrv_back #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_info    (pop_info),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/sv/quaternion_to_rotation_vector_unit_test.sv */
`timescale 1ns / 1ps
module quaternion_to_rotation_vector_unit_test;
   import qrv_pkg::*;

   localparam int STAGES    = 30;
   localparam int LATENCY   = STAGES + 70;
   localparam int WDOG_MAX  = 20000;
   localparam int N_RANDOM  = 830;
   localparam logic [31:0] Q_ONE = 32'h4000_0000;

   typedef struct packed {
      logic    chk;
      req_type q;
      rsp_type r;
   } row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en = 1'b0;
   logic [9:0] csr_wr_data = '0;

   logic [9:0] margin = MARGIN_RESET;
   rsp_type    rot_expected[$];
   int         fail_cnt = 0;
   int         idle_cycles = 0;

   quaternion_to_rotation_vector_unit #(.CORDIC_STAGES(STAGES)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint atan_step(int i);
      longint head[11] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                           33543515, 16775850, 8388437, 4194282, 2097149, 1048575};
      if (i < 11) return head[i];
      if (i <= 30) return (64'sd1 <<< (30 - i)) - 1;
      return 0;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // round to nearest, apply sign, saturate
   function automatic logic [31:0] round_div(bit neg, logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      q = (num + den / 2) / den;
      if (neg) return (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
      return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
   endfunction

   function automatic longint vector_angle(longint w, longint m);
      longint x, y, z, nx, ny;
      if (w < 0) begin
         x = m <<< 24; y = (-w) <<< 24; z = 1686629713;
      end else begin
         x = w <<< 24; y = m <<< 24; z = 0;
      end
      for (int i = 0; i < STAGES; i++) begin
         if (y >= 0) begin
            nx = x + shr_floor(y, i); ny = y - shr_floor(x, i); z += atan_step(i);
         end else begin
            nx = x - shr_floor(y, i); ny = y + shr_floor(x, i); z -= atan_step(i);
         end
         x = nx; y = ny;
      end
      return z < 0 ? 0 : z;
   endfunction

   function automatic rsp_type log_map(req_type q, logic [9:0] mg);
      rsp_type r;
      longint w, v[3], ang;
      logic [63:0] mag[3], s, m, den;
      r = '0;
      w = q.quat_w;
      v[0] = q.quat_x; v[1] = q.quat_y; v[2] = q.quat_z;
      for (int k = 0; k < 3; k++) mag[k] = v[k] < 0 ? -v[k] : v[k];
      if ((64'sd1 <<< 30) - w < longint'(mg)) begin
         den = w + (64'sd1 <<< 31);
         r.rot_x = round_div(v[0] < 0, mag[0] * 6 * (64'd1 << 28), den);
         r.rot_y = round_div(v[1] < 0, mag[1] * 6 * (64'd1 << 28), den);
         r.rot_z = round_div(v[2] < 0, mag[2] * 6 * (64'd1 << 28), den);
         return r;
      end
      s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      m = int_sqrt(s);
      if (m == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      ang = vector_angle(w, longint'(m));
      r.rot_x = round_div(v[0] < 0, mag[0] * ang, 2 * m);
      r.rot_y = round_div(v[1] < 0, mag[1] * ang, 2 * m);
      r.rot_z = round_div(v[2] < 0, mag[2] * ang, 2 * m);
      return r;
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [31:0] rand_field();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '0;
         3: return $urandom_range(0, 2000) - 1000;
         default: return $urandom;
      endcase
   endfunction

   // mostly unit-ish quaternions, some near identity, some noise
   function automatic req_type rand_quat();
      req_type q;
      int p;
      p = $urandom_range(0, 9);
      q.quat_x = rand_field(); q.quat_y = rand_field(); q.quat_z = rand_field();
      if (p < 3) begin
         q.quat_w = Q_ONE - $urandom_range(0, 1100) + $urandom_range(0, 50);
         q.quat_x = $urandom_range(0, 40000) - 20000;
         q.quat_y = $urandom_range(0, 40000) - 20000;
         q.quat_z = $urandom_range(0, 40000) - 20000;
      end else if (p < 8) begin
         q.quat_w = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
         q.quat_x = 32'($signed(q.quat_x) >>> $urandom_range(1, 4));
         q.quat_y = 32'($signed(q.quat_y) >>> $urandom_range(1, 4));
         q.quat_z = 32'($signed(q.quat_z) >>> $urandom_range(1, 4));
      end else begin
         q.quat_w = rand_field();
      end
      return q;
   endfunction

   // valid stays high into the next word when there is no gap
   task automatic send_quat(req_type q, rsp_type typed, bit typed_on);
      rsp_type pred;
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      pred = log_map(q, margin);
      if (typed_on && pred !== typed) begin
         $display("%0t table row disagrees: expected %h, predicted %h", $time, typed, pred);
         fail_cnt++;
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rot_expected.push_back(pred);
   endtask

   task automatic drain_and_write(logic [9:0] val);
      req_valid <= 1'b0;
      while (rot_expected.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      margin = val;
   endtask

   row_type rows[] = '{
      '{1'b1, '{Q_ONE, 32'd0, 32'd0, 32'd0}, '{32'd0, 32'd0, 32'd0, 1'b0}},
      '{1'b1, '{32'hC000_0000, 32'd0, 32'd0, 32'd0}, '{32'd0, 32'd0, 32'd0, 1'b1}},
      '{1'b1, '{32'd0, 32'd0, 32'd0, 32'd0}, '{32'd0, 32'd0, 32'd0, 1'b1}},
      '{1'b1, '{32'h8000_0000, 32'd0, 32'd0, 32'd0}, '{32'd0, 32'd0, 32'd0, 1'b1}},
      '{1'b0, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1}, '0},
      '{1'b0, '{32'd0, Q_ONE, 32'd0, 32'd0}, '0},
      '{1'b0, '{32'hC000_0000, 32'd0, Q_ONE, 32'd0}, '0},
      '{1'b0, '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, '0},
      '{1'b0, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, '0},
      '{1'b0, '{32'hC000_0001, 32'd1, 32'd0, 32'd0}, '0},
      '{1'b0, '{32'h2D41_3CCD, 32'h2D41_3CCD, 32'd0, 32'd0}, '0},
      '{1'b0, '{32'hD2BE_C333, 32'd0, 32'd0, 32'hD2BE_C333}, '0},
      '{1'b0, '{32'h3FFF_FFFF, 32'd5, 32'hFFFF_FFFB, 32'd7}, '0},
      '{1'b0, '{32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0}, '0},
      '{1'b0, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF}, '0},
      '{1'b0, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0}, '0}
   };

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) send_quat(rows[i].q, rows[i].r, rows[i].chk);
      // near-identity rows at a wide margin
      drain_and_write(10'd1023);
      send_quat('{Q_ONE - 32'd1022, 32'd40000, 32'hFFFF_0000, 32'd1}, '0, 1'b0);
      send_quat('{Q_ONE - 32'd1023, 32'd400, 32'd0, 32'd0}, '0, 1'b0);
      send_quat('{Q_ONE - 32'd1023, 32'd0, 32'd0, 32'd0}, '0, 1'b0);
      drain_and_write(10'd0);
      send_quat('{Q_ONE, 32'd3, 32'd0, 32'd0}, '0, 1'b0);
      send_quat('{Q_ONE + 32'd5, 32'd3, 32'd0, 32'd0}, '0, 1'b0);
      for (int ph = 0; ph < 4; ph++) begin
         drain_and_write(ph == 0 ? 10'd1 : ph == 1 ? 10'd1023 :
                         ph == 2 ? 10'($urandom_range(2, 1022)) : 10'd0);
         for (int n = 0; n < N_RANDOM / 4; n++) begin
            send_quat(rand_quat(), '0, 1'b0);
            if (ph == 1 && n == 100) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (rot_expected.size() != 0);
            end
         end
      end
      req_valid <= 1'b0;
      while (rot_expected.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      if (fail_cnt == 0) begin
         $display("quaternion_to_rotation_vector_unit_test passed");
      end else begin
         $display("quaternion_to_rotation_vector_unit_test failed");
      end
      $finish;
   end

   // stall the result side, with calm stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 999) < 3) begin
         rsp_stall <= 1'b1;
      end else if (rsp_stall && $urandom_range(0, 99) < 8) begin
         rsp_stall <= 1'b0;
      end else if (!rsp_stall && $urandom_range(0, 99) < 12) begin
         rsp_stall <= 1'b1;
      end else if (rsp_stall && $urandom_range(0, 99) < 50) begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rot_expected.size() == 0) begin
            $display("%0t unexpected word: actual %h", $time, rsp_data);
            fail_cnt++;
         end else begin
            want = rot_expected.pop_front();
            if (rsp_data.rot_x !== want.rot_x)
               $display("%0t rot_x: expected %h, actual %h", $time, want.rot_x, rsp_data.rot_x);
            if (rsp_data.rot_y !== want.rot_y)
               $display("%0t rot_y: expected %h, actual %h", $time, want.rot_y, rsp_data.rot_y);
            if (rsp_data.rot_z !== want.rot_z)
               $display("%0t rot_z: expected %h, actual %h", $time, want.rot_z, rsp_data.rot_z);
            if (rsp_data.degenerate !== want.degenerate)
               $display("%0t degenerate: expected %b, actual %b", $time, want.degenerate,
                        rsp_data.degenerate);
            if (rsp_data !== want) fail_cnt++;
         end
      end
   end

   // watchdog on cycles with no accepted word on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_MAX) begin
            $display("quaternion_to_rotation_vector_unit_test failed");
            $finish;
         end
      end
   end

endmodule
